/* hdl/assert_macros.svh */
// assertion macros shared by the natural log series block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// concurrent check on clk_i, off while rst_ni is low
`define NLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// concurrent check on clk_i, also active during reset
`define NLS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define NLS_ASSERT(lbl, prop, msg)
`define NLS_ASSERT_NR(lbl, prop, msg)
`endif
`endif

/* hdl/nls_pkg.sv */
// types and constants for the natural log series block
`default_nettype none
package nls_pkg;

  // number format
  localparam int FracBits = 30;
  localparam int OutShift = 4;
  localparam int XW       = 32;
  localparam int EpsW     = 31;
  localparam int TermsW   = 16;
  localparam int LogW     = 32;
  localparam int PW       = FracBits + 1;
  localparam int ProdW    = 2 * PW;
  localparam int SumW     = PW + TermsW + 2;
  localparam int CmpW     = (PW > EpsW) ? PW : EpsW;
  localparam int DivCntW  = $clog2(PW);

  localparam logic [EpsW-1:0]   EpsReset      = EpsW'(1074);
  localparam logic [TermsW-1:0] MaxTermsReset = TermsW'(4096);

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_DOMAIN = 2'd1,
    STATUS_RANGE  = 2'd2,
    STATUS_CAP    = 2'd3
  } nls_status_e;

  // register indexes
  typedef enum logic {
    CFG_EPSILON   = 1'b0,
    CFG_MAX_TERMS = 1'b1
  } nls_cfg_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic acc;
    logic mul;
    logic next_term;
    logic emit;
  } nls_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_arg;
    logic div_last;
    logic small_term;
    logic cap_hit;
  } nls_sts_t;

endpackage
`default_nettype wire

/* hdl/nls_ctrl.sv */
// sequencer for the series: argument check, divide, accumulate, next power
`default_nettype none
`include "assert_macros.svh"
module nls_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              out_free_i,
  input  wire nls_pkg::nls_sts_t sts_i,
  output nls_pkg::nls_cmd_t      cmd_o,
  output logic                   idle_o
);
  import nls_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_INIT   = 7'b0000010,
    ST_DIV    = 7'b0000100,
    ST_ACC    = 7'b0001000,
    ST_MUL    = 7'b0010000,
    ST_NEXT   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    idle_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_INIT;
        end
      end
      ST_INIT: begin
        if (sts_i.bad_arg) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.small_term || sts_i.cap_hit) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.next_term = 1'b1;
        state_d         = ST_INIT;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `NLS_ASSERT(a_div_to_acc, cmd_o.div_step && sts_i.div_last |=> state_q == ST_ACC, "divide did not hand over to accumulate")
  `NLS_ASSERT(a_emit_free, cmd_o.emit |-> out_free_i, "result emitted over a held beat")
  `NLS_ASSERT(a_load_init, cmd_o.load |=> state_q == ST_INIT, "load not followed by argument check")

endmodule
`default_nettype wire

/* hdl/nls_dp.sv */
// datapath: power register, multiplier, radix-2 divider, sum and output rounding
`default_nettype none
`include "assert_macros.svh"
module nls_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire nls_pkg::nls_cmd_t           cmd_i,
  input  wire logic [nls_pkg::XW-1:0]      x_value_i,
  input  wire logic [nls_pkg::EpsW-1:0]    epsilon_i,
  input  wire logic [nls_pkg::TermsW-1:0]  max_terms_i,
  output nls_pkg::nls_sts_t                sts_o,
  output logic [nls_pkg::LogW-1:0]         log_value_o,
  output nls_pkg::nls_status_e             status_o,
  output logic [nls_pkg::TermsW-1:0]       terms_used_o
);
  import nls_pkg::*;

  localparam logic [XW-1:0]   OneX   = XW'(1) << FracBits;
  localparam logic [XW-1:0]   TwoX   = XW'(1) << (FracBits + 1);
  localparam logic [SumW-1:0] Half   = SumW'(1) << (OutShift - 1);
  localparam logic [SumW-1:0] MaxNeg = SumW'(1) << (LogW - 1);
  localparam logic [SumW-1:0] MaxPos = MaxNeg - SumW'(1);

  logic                yneg_q, bad_q;
  logic [PW-1:0]       a_q, p_q, div_q;
  logic [TermsW-1:0]   k_q, rem_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [ProdW-1:0]    prod_q;
  logic [SumW-1:0]     sum_q;
  nls_status_e         status_q;

  // argument decode
  logic          x_zero, x_over, x_below;
  logic [XW-1:0] a_full;
  assign x_zero  = (x_value_i == '0);
  assign x_over  = (x_value_i > TwoX);
  assign x_below = (x_value_i < OneX);
  assign a_full  = x_below ? (OneX - x_value_i) : (x_value_i - OneX);

  // one restoring divide step
  logic [TermsW:0] rem_sh, rem_diff;
  logic            rem_ge;
  assign rem_sh   = {rem_q, div_q[PW-1]};
  assign rem_diff = rem_sh - {1'b0, k_q};
  assign rem_ge   = (rem_sh >= {1'b0, k_q});

  // stop tests on the finished quotient and the term index, and the term sign
  logic [TermsW-1:0] cap;
  logic              minus;
  assign cap   = (max_terms_i == '0) ? TermsW'(1) : max_terms_i;
  assign minus = yneg_q || !k_q[0];

  assign sts_o.bad_arg    = bad_q;
  assign sts_o.div_last   = (cnt_q == DivCntW'(PW - 1));
  assign sts_o.small_term = (CmpW'(div_q) <= CmpW'(epsilon_i));
  assign sts_o.cap_hit    = (k_q >= cap);

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      yneg_q <= x_below;
      bad_q  <= x_zero || x_over;
      a_q    <= a_full[PW-1:0];
      p_q    <= a_full[PW-1:0];
      sum_q  <= '0;
      k_q    <= (x_zero || x_over) ? '0 : TermsW'(1);
      if (x_zero) begin
        status_q <= STATUS_DOMAIN;
      end else if (x_over) begin
        status_q <= STATUS_RANGE;
      end else begin
        status_q <= STATUS_OK;
      end
    end
    if (cmd_i.div_init) begin
      div_q <= p_q;
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_diff[TermsW-1:0] : rem_sh[TermsW-1:0];
      div_q <= {div_q[PW-2:0], rem_ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.acc) begin
      sum_q    <= minus ? (sum_q - SumW'(div_q)) : (sum_q + SumW'(div_q));
      status_q <= sts_o.small_term ? STATUS_OK : STATUS_CAP;
    end
    if (cmd_i.mul) begin
      prod_q <= {{PW{1'b0}}, p_q} * {{PW{1'b0}}, a_q};
    end
    if (cmd_i.next_term) begin
      p_q <= prod_q[FracBits +: PW];
      k_q <= k_q + 1'b1;
    end
  end

  // round to nearest, halves away from zero, then saturate
  logic            sum_neg;
  logic [SumW-1:0] mag, rnd, sat;
  assign sum_neg = sum_q[SumW-1];
  assign mag     = sum_neg ? (SumW'(0) - sum_q) : sum_q;
  assign rnd     = (mag + Half) >> OutShift;
  always_comb begin
    if (sum_neg) begin
      sat = (rnd > MaxNeg) ? MaxNeg : rnd;
    end else begin
      sat = (rnd > MaxPos) ? MaxPos : rnd;
    end
  end
  assign log_value_o  = sum_neg ? LogW'(SumW'(0) - sat) : LogW'(sat);
  assign status_o     = status_q;
  assign terms_used_o = k_q;

  `NLS_ASSERT(a_div_k_nonzero, cmd_i.div_step |-> k_q != '0, "divide by a zero term index")
  `NLS_ASSERT(a_term_count, cmd_i.next_term |=> k_q == $past(k_q) + 1'b1, "term index did not advance")

endmodule
`default_nettype wire

/* hdl/natural_log_series.sv */
// top level of the natural log series block: config registers and output register
//
// ln(x) by the alternating series in y = x - 1, x in unsigned Q2.30, result in
// signed Q6.26 with a status code and the number of terms summed.
// Input channel: in_valid_i / in_stall_o with x_value_i; a beat is taken when
// valid is high and stall is low. Stall is high while an item is being worked.
// Output channel: out_valid_o / out_stall_i with log_value_o, status_o and
// terms_used_o, held in an output register that is free again once taken.
// Each term runs a one-bit-per-cycle divide of the power by the term index,
// then accumulate, multiply, power update and restart. An x of zero or
// above two is answered after the argument check, without summing.
// A new item is taken while a finished result waits; the block only holds in
// its finish step if the output register is still occupied and stalled.
// Config writes (cfg_we_i, cfg_index_i, cfg_data_i) belong in idle time.
// Reset returns to idle, empties the output register and restores epsilon
// to 1074 and max_terms to 4096.
`default_nettype none
`include "assert_macros.svh"
module natural_log_series (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [nls_pkg::EpsW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [nls_pkg::XW-1:0]      x_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [nls_pkg::LogW-1:0]         log_value_o,
  output logic [1:0]                       status_o,
  output logic [nls_pkg::TermsW-1:0]       terms_used_o
);
  import nls_pkg::*;

  logic [EpsW-1:0]   epsilon_q;
  logic [TermsW-1:0] max_terms_q;
  logic              out_valid_q;
  logic [LogW-1:0]   log_value_q;
  nls_status_e       status_q;
  logic [TermsW-1:0] terms_used_q;

  nls_cmd_t          cmd;
  nls_sts_t          sts;
  logic              idle, out_free;
  logic [LogW-1:0]   dp_log;
  nls_status_e       dp_status;
  logic [TermsW-1:0] dp_terms;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !idle;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epsilon_q   <= EpsReset;
      max_terms_q <= MaxTermsReset;
    end else if (cfg_we_i) begin
      case (nls_cfg_e'(cfg_index_i))
        CFG_EPSILON:   epsilon_q   <= cfg_data_i;
        CFG_MAX_TERMS: max_terms_q <= cfg_data_i[TermsW-1:0];
        default: begin
        end
      endcase
    end
  end

  nls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  nls_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .x_value_i    (x_value_i),
    .epsilon_i    (epsilon_q),
    .max_terms_i  (max_terms_q),
    .sts_o        (sts),
    .log_value_o  (dp_log),
    .status_o     (dp_status),
    .terms_used_o (dp_terms)
  );

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      log_value_q  <= dp_log;
      status_q     <= dp_status;
      terms_used_q <= dp_terms;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign log_value_o  = log_value_q;
  assign status_o     = status_q;
  assign terms_used_o = terms_used_q;

  `NLS_ASSERT(a_busy_after_take, in_valid_i && !in_stall_o |=> in_stall_o, "second beat taken while busy")

endmodule
`default_nettype wire

/* dv/tb_natural_log_series.sv */
// testbench for the natural log series block: directed table, random phases, scoreboard
module tb_natural_log_series;
  import nls_pkg::*;

  localparam int RandomPhases   = 10;
  localparam int ItemsPerPhase  = 60;
  localparam int HoldOffCycles  = 4000;
  localparam int TailCycles     = 200;
  localparam int WatchdogLimit  = 600000;

  typedef struct packed {
    logic [LogW-1:0]   log_value;
    nls_status_e       status;
    logic [TermsW-1:0] terms;
  } log_result_t;

  typedef enum logic {
    STEP_ITEM   = 1'b0,
    STEP_CONFIG = 1'b1
  } step_e;

  typedef struct {
    step_e             kind;
    logic [XW-1:0]     x;
    logic [EpsW-1:0]   eps;
    logic [TermsW-1:0] max_terms;
    bit                typed;
    log_result_t       want;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_index_i = 1'b0;
  logic [EpsW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [XW-1:0]     x_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [LogW-1:0]   log_value_o;
  logic [1:0]        status_o;
  logic [TermsW-1:0] terms_used_o;

  // register copies for prediction
  logic [EpsW-1:0]   eps_q = EpsReset;
  logic [TermsW-1:0] max_terms_q = MaxTermsReset;

  log_result_t expected_logs[$];
  stim_row_t   stim_rows[$];
  bit          fail_seen = 1'b0;
  bit          offering = 1'b0;
  int          results_seen = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;

  natural_log_series i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .x_value_i    (x_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .log_value_o  (log_value_o),
    .status_o     (status_o),
    .terms_used_o (terms_used_o)
  );

  always #5 clk_i = ~clk_i;

  // series sum of ln(x) with the current register settings
  function automatic log_result_t predict_log(input logic [XW-1:0] x);
    logic [63:0]        one_q;
    logic [63:0]        xv;
    logic [63:0]        a;
    logic [63:0]        power;
    logic [63:0]        term;
    logic [63:0]        k;
    logic [63:0]        cap;
    logic [63:0]        mag;
    logic signed [63:0] acc;
    logic               neg_y;
    logic               done;
    log_result_t        r;
    one_q = 64'd1 << FracBits;
    xv    = 64'(x);
    r     = '0;
    if (xv == 0) begin
      r.status = STATUS_DOMAIN;
      return r;
    end
    if (xv > 2 * one_q) begin
      r.status = STATUS_RANGE;
      return r;
    end
    neg_y = xv < one_q;
    a     = neg_y ? one_q - xv : xv - one_q;
    cap   = (max_terms_q == 0) ? 64'd1 : 64'(max_terms_q);
    power = a;
    k     = 1;
    acc   = 0;
    done  = 1'b0;
    while (!done) begin
      term = power / k;
      // all terms negative below one, alternating above
      if (neg_y || !k[0]) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
      if (term <= 64'(eps_q)) begin
        r.status = STATUS_OK;
        done = 1'b1;
      end else if (k >= cap) begin
        r.status = STATUS_CAP;
        done = 1'b1;
      end else begin
        power = (power * a) >> FracBits;
        k++;
      end
    end
    // round to the output format, halves away from zero, then saturate
    mag = acc[63] ? 64'(-acc) : 64'(acc);
    mag = (mag + (64'd1 << (OutShift - 1))) >> OutShift;
    if (acc[63]) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      r.log_value = LogW'(-mag);
    end else begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      r.log_value = mag[LogW-1:0];
    end
    r.terms = k[TermsW-1:0];
    return r;
  endfunction

  function automatic logic [XW-1:0] random_x(input bit near_one);
    logic [XW-1:0] one_q;
    one_q = XW'(1) << FracBits;
    // near one the series converges in a handful of terms
    if (near_one) return one_q - 32'h1000_0000 + $urandom_range(0, 32'h2000_0000);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return XW'(1);
          2: return one_q;
          3: return 2 * one_q;
          default: return 2 * one_q + 1;
        endcase
      end
      default: return $urandom_range(1, 32'h8000_0000);
    endcase
  endfunction

  function automatic void add_item(input logic [XW-1:0] x);
    stim_row_t row;
    row = '{STEP_ITEM, x, '0, '0, 1'b0, '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_typed(input logic [XW-1:0] x, input log_result_t want);
    stim_row_t row;
    row = '{STEP_ITEM, x, '0, '0, 1'b1, want};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_config(input logic [EpsW-1:0] eps,
                                     input logic [TermsW-1:0] max_terms);
    stim_row_t row;
    row = '{STEP_CONFIG, '0, eps, max_terms, 1'b0, '0};
    stim_rows.push_back(row);
  endfunction

  // input valid changes only when its value changes
  task automatic set_valid(input bit v);
    if (offering != v) begin
      in_valid_i <= v;
      offering = v;
    end
  endtask

  // bursts of random length, random gaps in between
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
      if (gap > 0) begin
        set_valid(1'b0);
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // offer one beat, record its expected result once taken
  task automatic send_item(input logic [XW-1:0] x, input bit typed, input log_result_t want);
    set_valid(1'b1);
    x_value_i <= x;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_logs.push_back(typed ? want : predict_log(x));
    pace();
  endtask

  task automatic wait_idle();
    set_valid(1'b0);
    while (expected_logs.size() != 0) @(posedge clk_i);
  endtask

  // both registers, written only once the block has gone idle
  task automatic set_config(input logic [EpsW-1:0] eps, input logic [TermsW-1:0] max_terms);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_EPSILON;
    cfg_data_i  <= eps;
    @(posedge clk_i);
    cfg_index_i <= CFG_MAX_TERMS;
    cfg_data_i  <= EpsW'(max_terms);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    eps_q       = eps;
    max_terms_q = max_terms;
  endtask

  // result scoreboard
  always @(posedge clk_i) begin
    log_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_logs.size() == 0) begin
        $error("result beat with nothing expected: log_value %h status %0d terms %0d",
               log_value_o, status_o, terms_used_o);
        fail_seen = 1'b1;
      end else begin
        want = expected_logs.pop_front();
        if (log_value_o !== want.log_value) begin
          $error("log_value: expected %h, got %h", want.log_value, log_value_o);
          fail_seen = 1'b1;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_seen = 1'b1;
        end
        if (terms_used_o !== want.terms) begin
          $error("terms_used: expected %0d, got %0d", want.terms, terms_used_o);
          fail_seen = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off while items keep coming
  initial begin
    int  mode_len;
    bit  held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && results_seen >= 150 && in_valid_i) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        mode_len = $urandom_range(1, 64);
        case ($urandom_range(0, 2))
          0: repeat (mode_len) begin
            out_stall_i <= 1'b0;
            @(posedge clk_i);
          end
          1: repeat (mode_len) begin
            out_stall_i <= ($urandom_range(0, 1) == 1);
            @(posedge clk_i);
          end
          default: repeat (mode_len) begin
            out_stall_i <= ($urandom_range(0, 3) != 0);
            @(posedge clk_i);
          end
        endcase
      end
    end
  end

  initial begin
    int        phase;
    int        n;
    bit        long_run;
    stim_row_t row;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, starting from the reset settings
    add_typed(32'h0000_0000, log_result_t'{'0, STATUS_DOMAIN, '0});
    add_typed(32'h8000_0001, log_result_t'{'0, STATUS_RANGE, '0});
    add_typed(32'hFFFF_FFFF, log_result_t'{'0, STATUS_RANGE, '0});
    add_typed(32'h4000_0000, log_result_t'{'0, STATUS_OK, 16'd1});
    add_item(32'h4000_0001);
    add_item(32'h3FFF_FFFF);
    add_item(32'h6000_0000);
    add_item(32'h2000_0000);
    // smallest x runs into the reset term cap
    add_item(32'h0000_0001);
    // zero epsilon, zero cap acting as one
    add_config('0, '0);
    add_typed(32'h8000_0000, log_result_t'{32'h0400_0000, STATUS_CAP, 16'd1});
    add_typed(32'h4000_0000, log_result_t'{'0, STATUS_OK, 16'd1});
    add_item(32'h0000_0001);
    // x of exactly two ends on the cap, tiny y ends on a zero term
    add_config('0, 16'd24);
    add_item(32'h8000_0000);
    add_item(32'h4000_0004);
    add_item(32'h3FFF_FFFC);
    add_typed(32'hC000_0000, log_result_t'{'0, STATUS_RANGE, '0});
    // epsilon of one and the largest cap
    add_config(31'h4000_0000, 16'hFFFF);
    add_item(32'h8000_0000);
    add_item(32'h0000_0001);
    add_item(32'h7FFF_FFFF);
    add_config(31'h7FFF_FFFF, 16'd3);
    add_item(32'h1000_0000);
    add_config(31'd1, 16'd1);
    add_item(32'h5000_0000);
    add_item(32'h3000_0000);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == STEP_CONFIG) begin
        set_config(row.eps, row.max_terms);
      end else begin
        send_item(row.x, row.typed, row.want);
      end
    end

    // random phases: short caps over all x, long caps near one
    for (phase = 0; phase < RandomPhases; phase++) begin
      long_run = phase[0];
      if (long_run) begin
        set_config(EpsW'($urandom_range(1, 32'h0010_0000)), TermsW'($urandom_range(41, 65535)));
      end else begin
        set_config(($urandom_range(0, 3) == 0) ? EpsW'($urandom) : EpsW'($urandom_range(0, 4096)),
                   TermsW'($urandom_range(0, 40)));
      end
      for (n = 0; n < ItemsPerPhase; n++) begin
        send_item(random_x(long_run), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (!fail_seen) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/nls_pkg.sv
hdl/nls_ctrl.sv
hdl/nls_dp.sv
hdl/natural_log_series.sv
dv/tb_natural_log_series.sv
